FILE: rtl/rmth_pkg.sv
// ----------------------------------------------------------------------------
// rmth_pkg
// Shared types, sizes and helpers for the two-heap running median block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmth_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int CAPACITY    = 1024;
  localparam int HALF_DEPTH  = (CAPACITY + 1) / 2;
  localparam int IDX_BITS    = $clog2(HALF_DEPTH);
  localparam int SIZE_BITS   = $clog2(HALF_DEPTH + 1);
  localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
  localparam int MED_BITS    = SAMPLE_BITS + 1;
  localparam int CHILD_BITS  = IDX_BITS + 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [MED_BITS-1:0]    median_t;
  typedef logic [IDX_BITS-1:0]           idx_t;
  typedef logic [SIZE_BITS-1:0]          size_t;
  typedef logic [COUNT_BITS-1:0]         count_t;
  typedef logic [CHILD_BITS-1:0]         child_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DN_RD,
    ST_DN_CMP,
    ST_UP_START,
    ST_UP_STEP,
    ST_UP_CMP,
    ST_DONE
  } state_t;

  // True when a belongs above b in the heap order.
  function automatic logic ahead(input sample_t a, input sample_t b, input logic is_max);
    ahead = is_max ? (a > b) : (a < b);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rmth_sample_if.sv
// ----------------------------------------------------------------------------
// rmth_sample_if
// Valid/ready channel carrying one input sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmth_sample_if;
  logic              valid;
  logic              ready;
  rmth_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

FILE: rtl/rmth_result_if.sv
// ----------------------------------------------------------------------------
// rmth_result_if
// Valid/ready channel carrying one median result.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmth_result_if;
  logic              valid;
  logic              ready;
  rmth_pkg::median_t median_doubled;
  rmth_pkg::count_t  element_count;
  logic              dropped_full;

  modport source (output valid, output median_doubled, output element_count,
                  output dropped_full, input ready);
  modport sink   (input valid, input median_doubled, input element_count,
                  input dropped_full, output ready);
endinterface

`default_nettype wire

FILE: rtl/running_median_two_heaps.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps
// Running median of signed samples held in a max-heap and a min-heap.
// ----------------------------------------------------------------------------
// Each accepted sample joins the set unless the store is full, and yields
// one result: twice the median (one fractional bit), the number of samples
// held and a drop flag set when the store already holds CAPACITY samples.
// Both heaps live in single-write, dual-read memories with registered
// reads; every sift level reads, then compares and writes. The longest
// path for a sample is one sift-down and one sift-up pass. One sample is
// worked on at a time; a finished result waits in an output register
// while the next sample enters.
`default_nettype none

module running_median_two_heaps (
  input  wire logic          clk,
  input  wire logic          rst,
  rmth_sample_if.sink        samples,
  rmth_result_if.source      results
);

  rmth_pkg::state_t  state, state_next;
  rmth_pkg::sample_t x, x_next;
  rmth_pkg::sample_t v, v_next;
  rmth_pkg::idx_t    idx, idx_next;
  rmth_pkg::size_t   heap_n, heap_n_next;
  logic              on_upper, on_upper_next;
  logic              push_pend, push_pend_next;
  logic              push_upper, push_upper_next;
  rmth_pkg::sample_t push_val, push_val_next;
  logic              dropped, dropped_next;
  rmth_pkg::size_t   lower_size, lower_size_next;
  rmth_pkg::size_t   upper_size, upper_size_next;
  rmth_pkg::sample_t lower_top, upper_top;

  logic              out_valid;
  rmth_pkg::median_t out_median;
  rmth_pkg::count_t  out_count;
  logic              out_dropped;
  logic              out_load;

  rmth_pkg::sample_t lower_mem [rmth_pkg::HALF_DEPTH];
  rmth_pkg::sample_t upper_mem [rmth_pkg::HALF_DEPTH];
  rmth_pkg::sample_t lo_rd_a, lo_rd_b, up_rd_a, up_rd_b, rd_a, rd_b;
  rmth_pkg::idx_t    rd_addr_a, rd_addr_b, wr_addr;
  logic              wr_en, wr_upper;
  rmth_pkg::sample_t wr_data;

  rmth_pkg::count_t  count;
  rmth_pkg::child_t  child_l, child_r;
  rmth_pkg::idx_t    parent, step_parent;
  rmth_pkg::size_t   cur_size;
  logic              take_l, take_r;
  rmth_pkg::sample_t best_lv;
  rmth_pkg::median_t median;

  assign count = rmth_pkg::COUNT_BITS'(lower_size) + rmth_pkg::COUNT_BITS'(upper_size);
  assign rd_a  = on_upper ? up_rd_a : lo_rd_a;
  assign rd_b  = on_upper ? up_rd_b : lo_rd_b;

  assign child_l = {1'b0, idx, 1'b1};
  assign child_r = child_l + rmth_pkg::CHILD_BITS'(1);
  assign parent  = (idx - rmth_pkg::IDX_BITS'(1)) >> 1;
  assign step_parent = parent;
  assign cur_size = on_upper ? upper_size : lower_size;

  assign take_l  = (child_l < rmth_pkg::CHILD_BITS'(heap_n)) && rmth_pkg::ahead(rd_a, v, !on_upper);
  assign best_lv = take_l ? rd_a : v;
  assign take_r  = (child_r < rmth_pkg::CHILD_BITS'(heap_n)) &&
                   rmth_pkg::ahead(rd_b, best_lv, !on_upper);

  always_comb begin
    if (count[0] || (upper_size == '0)) begin
      median = rmth_pkg::median_t'(lower_top) + rmth_pkg::median_t'(lower_top);
    end else begin
      median = rmth_pkg::median_t'(lower_top) + rmth_pkg::median_t'(upper_top);
    end
  end

  assign samples.ready = (state == rmth_pkg::ST_IDLE);
  assign out_load      = (state == rmth_pkg::ST_DONE) && (!out_valid || results.ready);

  always_comb begin
    state_next      = state;
    x_next          = x;
    v_next          = v;
    idx_next        = idx;
    heap_n_next     = heap_n;
    on_upper_next   = on_upper;
    push_pend_next  = push_pend;
    push_upper_next = push_upper;
    push_val_next   = push_val;
    dropped_next    = dropped;
    lower_size_next = lower_size;
    upper_size_next = upper_size;
    rd_addr_a       = '0;
    rd_addr_b       = '0;
    wr_en           = 1'b0;
    wr_upper        = on_upper;
    wr_addr         = idx;
    wr_data         = v;
    case (state)
      rmth_pkg::ST_IDLE: begin
        if (samples.valid) begin
          x_next     = samples.sample;
          state_next = rmth_pkg::ST_DECIDE;
        end
      end
      rmth_pkg::ST_DECIDE: begin
        dropped_next   = 1'b0;
        push_pend_next = 1'b0;
        v_next         = x;
        idx_next       = '0;
        if (count >= rmth_pkg::COUNT_BITS'(rmth_pkg::CAPACITY)) begin
          dropped_next = 1'b1;
          state_next   = rmth_pkg::ST_DONE;
        end else if ((upper_size != '0) && (x > upper_top)) begin
          on_upper_next   = 1'b1;
          heap_n_next     = upper_size;
          push_pend_next  = 1'b1;
          push_val_next   = upper_top;
          push_upper_next = (lower_size == upper_size + rmth_pkg::SIZE_BITS'(1));
          state_next      = rmth_pkg::ST_DN_RD;
        end else if (lower_size == upper_size + rmth_pkg::SIZE_BITS'(1)) begin
          if (x >= lower_top) begin
            on_upper_next = 1'b1;
            state_next    = rmth_pkg::ST_UP_START;
          end else begin
            on_upper_next   = 1'b0;
            heap_n_next     = lower_size;
            push_pend_next  = 1'b1;
            push_val_next   = lower_top;
            push_upper_next = 1'b1;
            state_next      = rmth_pkg::ST_DN_RD;
          end
        end else begin
          on_upper_next = 1'b0;
          state_next    = rmth_pkg::ST_UP_START;
        end
      end
      rmth_pkg::ST_DN_RD: begin
        rd_addr_a  = child_l[rmth_pkg::IDX_BITS-1:0];
        rd_addr_b  = child_r[rmth_pkg::IDX_BITS-1:0];
        state_next = rmth_pkg::ST_DN_CMP;
      end
      rmth_pkg::ST_DN_CMP: begin
        wr_en = 1'b1;
        if (take_r) begin
          wr_data    = rd_b;
          idx_next   = child_r[rmth_pkg::IDX_BITS-1:0];
          state_next = rmth_pkg::ST_DN_RD;
        end else if (take_l) begin
          wr_data    = rd_a;
          idx_next   = child_l[rmth_pkg::IDX_BITS-1:0];
          state_next = rmth_pkg::ST_DN_RD;
        end else if (push_pend) begin
          push_pend_next = 1'b0;
          on_upper_next  = push_upper;
          v_next         = push_val;
          state_next     = rmth_pkg::ST_UP_START;
        end else begin
          state_next = rmth_pkg::ST_DONE;
        end
      end
      rmth_pkg::ST_UP_START: begin
        idx_next = cur_size[rmth_pkg::IDX_BITS-1:0];
        if (on_upper) begin
          upper_size_next = upper_size + rmth_pkg::SIZE_BITS'(1);
        end else begin
          lower_size_next = lower_size + rmth_pkg::SIZE_BITS'(1);
        end
        state_next = rmth_pkg::ST_UP_STEP;
      end
      rmth_pkg::ST_UP_STEP: begin
        if (idx == '0) begin
          wr_en      = 1'b1;
          state_next = rmth_pkg::ST_DONE;
        end else begin
          rd_addr_a  = step_parent;
          state_next = rmth_pkg::ST_UP_CMP;
        end
      end
      rmth_pkg::ST_UP_CMP: begin
        wr_en = 1'b1;
        if (rmth_pkg::ahead(v, rd_a, !on_upper)) begin
          wr_data    = rd_a;
          idx_next   = parent;
          state_next = rmth_pkg::ST_UP_STEP;
        end else begin
          state_next = rmth_pkg::ST_DONE;
        end
      end
      rmth_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = rmth_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rmth_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rmth_pkg::ST_IDLE;
      lower_size <= '0;
      upper_size <= '0;
      push_pend  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      lower_size <= lower_size_next;
      upper_size <= upper_size_next;
      push_pend  <= push_pend_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    x          <= x_next;
    v          <= v_next;
    idx        <= idx_next;
    heap_n     <= heap_n_next;
    on_upper   <= on_upper_next;
    push_upper <= push_upper_next;
    push_val   <= push_val_next;
    dropped    <= dropped_next;
    if (wr_en && (wr_addr == '0)) begin
      if (wr_upper) begin
        upper_top <= wr_data;
      end else begin
        lower_top <= wr_data;
      end
    end
    if (out_load) begin
      out_median  <= median;
      out_count   <= count;
      out_dropped <= dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !wr_upper) begin
      lower_mem[wr_addr] <= wr_data;
    end
    lo_rd_a <= lower_mem[rd_addr_a];
    lo_rd_b <= lower_mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_upper) begin
      upper_mem[wr_addr] <= wr_data;
    end
    up_rd_a <= upper_mem[rd_addr_a];
    up_rd_b <= upper_mem[rd_addr_b];
  end

  assign results.valid          = out_valid;
  assign results.median_doubled = out_median;
  assign results.element_count  = out_count;
  assign results.dropped_full   = out_dropped;

  a_balance: assert property (@(posedge clk) disable iff (rst)
    (lower_size == upper_size) || (lower_size == upper_size + rmth_pkg::SIZE_BITS'(1)))
    else $error("heap sizes out of balance");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    count <= rmth_pkg::COUNT_BITS'(rmth_pkg::CAPACITY))
    else $error("element count above capacity");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.dropped_full) |->
      (results.element_count == rmth_pkg::COUNT_BITS'(rmth_pkg::CAPACITY)))
    else $error("drop reported with store not full");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> (state == rmth_pkg::ST_DECIDE))
    else $error("accepted transaction not decoded");

endmodule

`default_nettype wire
